// ----- rtl/core/rth_pkg.sv -----
// ----------------------------------------------------------------------------
// rth_pkg
// Shared constants and types for the RGB to HSV conversion pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Channel and hue field widths.
  localparam int unsigned CHANNEL_BITS  = 8;
  localparam int unsigned HUE_FRAC_BITS = 6;
  localparam int unsigned HUE_BITS      = 15;

  // Largest channel code, used as the saturation scale.
  localparam int unsigned CHAN_MAX   = (1 << CHANNEL_BITS) - 1;

  // One sixth of the hue circle, in hue units, and the sector offsets.
  localparam int unsigned HUE_SECTOR = 60 << HUE_FRAC_BITS;
  localparam int unsigned HUE_GREEN  = 2 * HUE_SECTOR;
  localparam int unsigned HUE_BLUE   = 4 * HUE_SECTOR;
  localparam int unsigned HUE_FULL   = 6 * HUE_SECTOR;

  // Quotient width: must hold both the hue fraction and the saturation.
  localparam int unsigned HUE_QUOT_BITS = $clog2(HUE_SECTOR + 1);
  localparam int unsigned QUOT_BITS     = (HUE_QUOT_BITS > CHANNEL_BITS) ?
                                          HUE_QUOT_BITS : CHANNEL_BITS;
  // Dividend width: quotient bits on top of the divisor width.
  localparam int unsigned DIV_BITS      = CHANNEL_BITS + QUOT_BITS;

  // Front stages, one divider stage per quotient bit, and the output stage.
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned LATENCY      = FRONT_STAGES + QUOT_BITS + 1;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } rth_sector_e;

  // One lane of the pipelined divider.
  typedef struct packed {
    logic [DIV_BITS-1:0]     rem;
    logic [CHANNEL_BITS-1:0] dsr;
    logic [QUOT_BITS-1:0]    quo;
  } rth_lane_t;

  // Pixel information that travels alongside the division.
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] value;
    rth_sector_e             sector;
    logic                    neg;
    logic                    grey;
    logic                    black;
  } rth_side_t;

endpackage

// ----- rtl/core/rth_classify.sv -----
// ----------------------------------------------------------------------------
// rth_classify
// Front end: registers the pixel, finds the maximum channel and the spread,
// then forms the two dividends for the divider.
// ----------------------------------------------------------------------------
module rth_classify (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [rth_pkg::CHANNEL_BITS-1:0] red_i,
  input  logic [rth_pkg::CHANNEL_BITS-1:0] green_i,
  input  logic [rth_pkg::CHANNEL_BITS-1:0] blue_i,
  output logic                             valid_o,
  output rth_pkg::rth_lane_t               hue_lane_o,
  output rth_pkg::rth_lane_t               sat_lane_o,
  output rth_pkg::rth_side_t               side_o
);

  // Stage one: input registers.
  logic                             s1_vld_q;
  logic [rth_pkg::CHANNEL_BITS-1:0] s1_r_q, s1_g_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s1_r_q <= red_i;
      s1_g_q <= green_i;
      s1_b_q <= blue_i;
    end
  end

  // Stage two: maximum, minimum, sector and the signed numerator.
  rth_pkg::rth_sector_e             sector_d;
  logic [rth_pkg::CHANNEL_BITS-1:0] mx_d, mn_d, plus_d, minus_d;
  logic                             neg_d;

  always_comb begin
    if (s1_r_q >= s1_g_q && s1_r_q >= s1_b_q) begin
      sector_d = rth_pkg::SECT_RED;
      mx_d     = s1_r_q;
      plus_d   = s1_g_q;
      minus_d  = s1_b_q;
    end else if (s1_g_q >= s1_b_q) begin
      sector_d = rth_pkg::SECT_GREEN;
      mx_d     = s1_g_q;
      plus_d   = s1_b_q;
      minus_d  = s1_r_q;
    end else begin
      sector_d = rth_pkg::SECT_BLUE;
      mx_d     = s1_b_q;
      plus_d   = s1_r_q;
      minus_d  = s1_g_q;
    end
    mn_d  = (s1_g_q < s1_r_q) ? s1_g_q : s1_r_q;
    mn_d  = (s1_b_q < mn_d) ? s1_b_q : mn_d;
    neg_d = (minus_d > plus_d);
  end

  logic                             s2_vld_q;
  rth_pkg::rth_sector_e             s2_sector_q;
  logic [rth_pkg::CHANNEL_BITS-1:0] s2_mx_q, s2_delta_q, s2_mag_q;
  logic                             s2_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_sector_q <= sector_d;
      s2_mx_q     <= mx_d;
      s2_delta_q  <= mx_d - mn_d;
      s2_mag_q    <= neg_d ? (minus_d - plus_d) : (plus_d - minus_d);
      s2_neg_q    <= neg_d;
    end
  end

  // Stage three: scaled dividends and the side information.
  logic               s3_vld_q;
  rth_pkg::rth_lane_t s3_hue_q, s3_sat_q;
  rth_pkg::rth_side_t s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      s3_hue_q.rem    <= rth_pkg::DIV_BITS'(s2_mag_q) *
                         rth_pkg::DIV_BITS'(rth_pkg::HUE_SECTOR);
      s3_hue_q.dsr    <= s2_delta_q;
      s3_hue_q.quo    <= '0;
      s3_sat_q.rem    <= rth_pkg::DIV_BITS'(s2_delta_q) *
                         rth_pkg::DIV_BITS'(rth_pkg::CHAN_MAX);
      s3_sat_q.dsr    <= s2_mx_q;
      s3_sat_q.quo    <= '0;
      s3_side_q.value  <= s2_mx_q;
      s3_side_q.sector <= s2_sector_q;
      s3_side_q.neg    <= s2_neg_q;
      s3_side_q.grey   <= (s2_delta_q == '0);
      s3_side_q.black  <= (s2_mx_q == '0);
    end
  end

  assign valid_o    = s3_vld_q;
  assign hue_lane_o = s3_hue_q;
  assign sat_lane_o = s3_sat_q;
  assign side_o     = s3_side_q;

endmodule

// ----- rtl/core/rth_divider.sv -----
// ----------------------------------------------------------------------------
// rth_divider
// Pipelined restoring divider with two lanes in lockstep, one quotient bit
// per stage, most significant bit first.
// ----------------------------------------------------------------------------
module rth_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rth_pkg::rth_lane_t            hue_lane_i,
  input  rth_pkg::rth_lane_t            sat_lane_i,
  input  rth_pkg::rth_side_t            side_i,
  output logic                          valid_o,
  output logic [rth_pkg::QUOT_BITS-1:0] hue_quo_o,
  output logic [rth_pkg::QUOT_BITS-1:0] sat_quo_o,
  output rth_pkg::rth_side_t            side_o
);

  // One restoring step: subtract the shifted divisor when it fits.
  function automatic rth_pkg::rth_lane_t div_step(input rth_pkg::rth_lane_t a,
                                                  input int unsigned sh);
    logic [rth_pkg::DIV_BITS-1:0] trial;
    rth_pkg::rth_lane_t           r;
    trial = rth_pkg::DIV_BITS'(a.dsr) << sh;
    r     = a;
    if (a.rem >= trial) begin
      r.rem = a.rem - trial;
      r.quo = a.quo | (rth_pkg::QUOT_BITS'(1) << sh);
    end
    return r;
  endfunction

  logic [rth_pkg::QUOT_BITS-1:0] vld_q;
  rth_pkg::rth_lane_t            hue_q  [rth_pkg::QUOT_BITS];
  rth_pkg::rth_lane_t            sat_q  [rth_pkg::QUOT_BITS];
  rth_pkg::rth_side_t            side_q [rth_pkg::QUOT_BITS];

  for (genvar k = 0; k < rth_pkg::QUOT_BITS; k++) begin : g_stage
    localparam int unsigned Shift = rth_pkg::QUOT_BITS - 1 - k;

    logic               vld_src;
    rth_pkg::rth_lane_t hue_src, sat_src;
    rth_pkg::rth_side_t side_src;

    // The first stage takes the front end, the others their predecessor.
    if (k == 0) begin : g_first
      assign vld_src  = valid_i;
      assign hue_src  = hue_lane_i;
      assign sat_src  = sat_lane_i;
      assign side_src = side_i;
    end else begin : g_next
      assign vld_src  = vld_q[k-1];
      assign hue_src  = hue_q[k-1];
      assign sat_src  = sat_q[k-1];
      assign side_src = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_src;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_src) begin
        hue_q[k]  <= div_step(hue_src, Shift);
        sat_q[k]  <= div_step(sat_src, Shift);
        side_q[k] <= side_src;
      end
    end
  end

  assign valid_o   = vld_q[rth_pkg::QUOT_BITS-1];
  assign hue_quo_o = hue_q[rth_pkg::QUOT_BITS-1].quo;
  assign sat_quo_o = sat_q[rth_pkg::QUOT_BITS-1].quo;
  assign side_o    = side_q[rth_pkg::QUOT_BITS-1];

endmodule

// ----- rtl/core/rth_finish.sv -----
// ----------------------------------------------------------------------------
// rth_finish
// Output stage: applies the sector offset and the grey and black special
// cases, and registers the result transaction.
// ----------------------------------------------------------------------------
module rth_finish (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [rth_pkg::QUOT_BITS-1:0]    hue_quo_i,
  input  logic [rth_pkg::QUOT_BITS-1:0]    sat_quo_i,
  input  rth_pkg::rth_side_t               side_i,
  output logic                             done_o,
  output logic [rth_pkg::HUE_BITS-1:0]     hue_o,
  output logic [rth_pkg::CHANNEL_BITS-1:0] saturation_o,
  output logic [rth_pkg::CHANNEL_BITS-1:0] value_o
);

  logic [rth_pkg::HUE_BITS-1:0]     base_d, quo_d, hue_d;
  logic [rth_pkg::CHANNEL_BITS-1:0] sat_d;

  // Offset by sector; a negative red hue wraps round from the full circle.
  always_comb begin
    unique case (side_i.sector)
      rth_pkg::SECT_RED: begin
        base_d = side_i.neg ? rth_pkg::HUE_BITS'(rth_pkg::HUE_FULL) : '0;
      end
      rth_pkg::SECT_GREEN: begin
        base_d = rth_pkg::HUE_BITS'(rth_pkg::HUE_GREEN);
      end
      rth_pkg::SECT_BLUE: begin
        base_d = rth_pkg::HUE_BITS'(rth_pkg::HUE_BLUE);
      end
      default: begin
        base_d = '0;
      end
    endcase
    quo_d = rth_pkg::HUE_BITS'(hue_quo_i);
    if (side_i.grey) begin
      hue_d = '0;
    end else if (side_i.neg) begin
      hue_d = base_d - quo_d;
    end else begin
      hue_d = base_d + quo_d;
    end
    sat_d = side_i.black ? '0 : sat_quo_i[rth_pkg::CHANNEL_BITS-1:0];
  end

  logic                             done_q;
  logic [rth_pkg::HUE_BITS-1:0]     hue_q;
  logic [rth_pkg::CHANNEL_BITS-1:0] sat_q, val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= side_i.value;
    end
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = val_q;

endmodule

// ----- rtl/core/rgb_to_hsv_converter_core.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// RGB to HSV colour conversion of one pixel per clock in a fixed-latency
// pipeline: classification, a bit-per-stage divider and an output stage.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake          Payload
//   -------  -----------------  ---------------------------------------
//   pixel    start_i / busy_o   red_i, green_i, blue_i
//   result   done_o (strobe)    hue_o, saturation_o, value_o
//
// A new pixel transaction may be started in every cycle; busy_o stays low.
// Each result passes from its start through three front stages, one
// divider stage per quotient bit (twelve) and one output register.
// Results leave in start order and cannot be held off by the receiver.
// Reset empties the pipeline by clearing the valid bits; no result is lost
// or repeated, since nothing ever waits.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [rth_pkg::CHANNEL_BITS-1:0] red_i,
  input  logic [rth_pkg::CHANNEL_BITS-1:0] green_i,
  input  logic [rth_pkg::CHANNEL_BITS-1:0] blue_i,
  output logic                             done_o,
  output logic [rth_pkg::HUE_BITS-1:0]     hue_o,
  output logic [rth_pkg::CHANNEL_BITS-1:0] saturation_o,
  output logic [rth_pkg::CHANNEL_BITS-1:0] value_o
);

  // The pipeline accepts a transaction in every cycle.
  assign busy_o = 1'b0;

  logic                          front_vld, div_vld;
  rth_pkg::rth_lane_t            hue_lane, sat_lane;
  rth_pkg::rth_side_t            front_side, div_side;
  logic [rth_pkg::QUOT_BITS-1:0] hue_quo, sat_quo;

  rth_classify u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i & ~busy_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .valid_o    (front_vld),
    .hue_lane_o (hue_lane),
    .sat_lane_o (sat_lane),
    .side_o     (front_side)
  );

  rth_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_vld),
    .hue_lane_i (hue_lane),
    .sat_lane_i (sat_lane),
    .side_i     (front_side),
    .valid_o    (div_vld),
    .hue_quo_o  (hue_quo),
    .sat_quo_o  (sat_quo),
    .side_o     (div_side)
  );

  rth_finish u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (div_vld),
    .hue_quo_i    (hue_quo),
    .sat_quo_i    (sat_quo),
    .side_i       (div_side),
    .done_o       (done_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o)
  );

endmodule

// ----- rtl/core/rth_checker.sv -----
// ----------------------------------------------------------------------------
// rth_checker
// Port-level checks on the converter: fixed latency, no invented results and
// the range and special cases of the result fields.
// ----------------------------------------------------------------------------
module rth_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic [rth_pkg::CHANNEL_BITS-1:0] red_i,
  input logic [rth_pkg::CHANNEL_BITS-1:0] green_i,
  input logic [rth_pkg::CHANNEL_BITS-1:0] blue_i,
  input logic                             done_o,
  input logic [rth_pkg::HUE_BITS-1:0]     hue_o,
  input logic [rth_pkg::CHANNEL_BITS-1:0] saturation_o,
  input logic [rth_pkg::CHANNEL_BITS-1:0] value_o
);

  // Every started transaction yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(rth_pkg::LATENCY) done_o)
    else $error("result missing after a started transaction");

  // No result appears without a transaction started at the matching time.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##(rth_pkg::LATENCY) !done_o)
    else $error("result without a started transaction");

  // Hue stays below the full circle.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_o < rth_pkg::HUE_BITS'(rth_pkg::HUE_FULL)))
    else $error("hue out of range");

  // A black pixel has neither saturation nor hue.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && value_o == '0) |-> (saturation_o == '0 && hue_o == '0))
    else $error("black pixel with non-zero hue or saturation");

  // A grey pixel has zero hue and saturation, and its value equals the common channel.
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(red_i == green_i && green_i == blue_i, rth_pkg::LATENCY))
    |-> (hue_o == '0 && saturation_o == '0 &&
         value_o == $past(red_i, rth_pkg::LATENCY)))
    else $error("grey pixel converted wrongly");

endmodule

bind rgb_to_hsv_converter_core rth_checker u_rth_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .red_i        (red_i),
  .green_i      (green_i),
  .blue_i       (blue_i),
  .done_o       (done_o),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .value_o      (value_o)
);
